// File: design/hte_pkg.sv
// Shared constants, types and register indexes for the homography transfer error scorer.
// No dependencies.
package hte_pkg;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 48;
    localparam int ERR_W      = 64;
    localparam int COEF_CNT   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int COORD_FRAC = 16;
    localparam int COEF_FRAC  = 32;
    localparam int QUOT_W     = 48;
    localparam int MUL_CHUNK  = 24;
    localparam int FWD_W      = 82;
    localparam int ADJ_W      = 98;
    localparam int BWD_W      = 132;
    localparam int DET_W      = 148;
    localparam int ADJ_CNT    = 9;
    localparam int CFG_SETTLE = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_00 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_01 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_02 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_10 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_11 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_12 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_20 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_21 = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) <<< COEF_FRAC;
    localparam logic signed [FWD_W-1:0]  FWD_ONE  = FWD_W'(1) <<< (COEF_FRAC + COORD_FRAC);
    localparam bit SYMMETRIC_DEF = 1'b1;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ADJ_W-1:0]  t_adj;

    typedef struct packed {
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
    } t_pts;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [ERR_W-1:0] err;
    } t_xfer_res;

endpackage

// File: design/hte_in_if.sv
// Input channel: one point correspondence per transfer.
// Depends on hte_pkg.
interface hte_in_if import hte_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;

    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

// File: design/hte_out_if.sv
// Output channel: one scored error per transfer.
// Depends on hte_pkg.
interface hte_out_if import hte_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ERR_W-1:0] squared_error;
    logic             is_infinite;
    logic             error_side;

    modport source (output valid, squared_error, is_infinite, error_side, input ready);
    modport sink   (input valid, squared_error, is_infinite, error_side, output ready);
endinterface

// File: design/hte_mul.sv
// Two-stage signed multiplier built from 25x25 partial products, then a registered sum.
// Depends on hte_pkg.
module hte_mul import hte_pkg::*; #(
    parameter int AW = COEF_W,
    parameter int BW = COORD_W
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [AW-1:0]  i_a,
    input  logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int CW = MUL_CHUNK;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int XA = NA * CW;
    localparam int XB = NB * CW;
    localparam int PW = AW + BW;

    logic signed [XA-1:0]     a_x;
    logic signed [XB-1:0]     b_x;
    logic signed [2*CW+1:0]   r_pp [NA][NB];
    logic signed [PW-1:0]     n_p;
    logic signed [PW-1:0]     r_p;

    assign a_x = XA'(i_a);
    assign b_x = XB'(i_b);

    for (genvar i = 0; i < NA; i++) begin : g_a
        for (genvar j = 0; j < NB; j++) begin : g_b
            logic signed [CW:0] a_c;
            logic signed [CW:0] b_c;
            if (i == NA - 1) begin : g_as
                assign a_c = {a_x[XA-1], a_x[i*CW +: CW]};
            end else begin : g_au
                assign a_c = {1'b0, a_x[i*CW +: CW]};
            end
            if (j == NB - 1) begin : g_bs
                assign b_c = {b_x[XB-1], b_x[j*CW +: CW]};
            end else begin : g_bu
                assign b_c = {1'b0, b_x[j*CW +: CW]};
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pp[i][j] <= a_c * b_c;
                end
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_p = n_p + (PW'(r_pp[i][j]) <<< (CW * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

// File: design/hte_coef.sv
// Free-running adjugate pipeline: sign(det(H)) * adj(H) and the nonzero-determinant flag.
// Depends on hte_pkg, hte_mul.
module hte_coef import hte_pkg::*; (
    input  logic  i_clk,
    input  t_coef i_coef [COEF_CNT],
    output t_adj  o_adj [ADJ_CNT],
    output logic  o_det_nz
);
    localparam int NPR = 14;
    localparam int PA [NPR] = '{5, 2, 1, 2, 5, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int PB [NPR] = '{7, 7, 5, 4, 6, 6, 3, 5, 7, 6, 6, 7, 4, 3};
    localparam int PRW = 2 * COEF_W;
    localparam int DPW = COEF_W + ADJ_W;

    logic signed [PRW-1:0]   w_pr [NPR];
    t_adj                    r_adj [ADJ_CNT];
    logic signed [DPW-1:0]   w_dp [3];
    logic signed [DET_W-1:0] r_det;
    t_adj                    r_sadj [ADJ_CNT];
    logic                    r_det_nz;

    for (genvar g = 0; g < NPR; g++) begin : g_pr
        hte_mul #(.AW(COEF_W), .BW(COEF_W)) u_mul (
            .i_clk (i_clk),
            .i_en  (1'b1),
            .i_a   (i_coef[PA[g]]),
            .i_b   (i_coef[PB[g]]),
            .o_p   (w_pr[g])
        );
    end

    function automatic t_adj sh1(input t_coef h);
        return ADJ_W'(h) <<< COEF_FRAC;
    endfunction

    function automatic t_adj ext(input logic signed [PRW-1:0] p);
        return ADJ_W'(p);
    endfunction

    always_ff @(posedge i_clk) begin
        r_adj[0] <= sh1(i_coef[CFG_COEF_11]) - ext(w_pr[0]);
        r_adj[1] <= ext(w_pr[1]) - sh1(i_coef[CFG_COEF_01]);
        r_adj[2] <= ext(w_pr[2]) - ext(w_pr[3]);
        r_adj[3] <= ext(w_pr[4]) - sh1(i_coef[CFG_COEF_10]);
        r_adj[4] <= sh1(i_coef[CFG_COEF_00]) - ext(w_pr[5]);
        r_adj[5] <= ext(w_pr[6]) - ext(w_pr[7]);
        r_adj[6] <= ext(w_pr[8]) - ext(w_pr[9]);
        r_adj[7] <= ext(w_pr[10]) - ext(w_pr[11]);
        r_adj[8] <= ext(w_pr[12]) - ext(w_pr[13]);
    end

    for (genvar g = 0; g < 3; g++) begin : g_det
        hte_mul #(.AW(COEF_W), .BW(ADJ_W)) u_mul (
            .i_clk (i_clk),
            .i_en  (1'b1),
            .i_a   (i_coef[g]),
            .i_b   (r_adj[3*g]),
            .o_p   (w_dp[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_det    <= DET_W'(w_dp[0]) + DET_W'(w_dp[1]) + DET_W'(w_dp[2]);
        r_det_nz <= (r_det != '0);
        for (int k = 0; k < ADJ_CNT; k++) begin
            r_sadj[k] <= r_det[DET_W-1] ? -r_adj[k] : r_adj[k];
        end
    end

    assign o_adj    = r_sadj;
    assign o_det_nz = r_det_nz;
endmodule

// File: design/hte_xfer.sv
// One projective transfer: restoring divide of both coordinates by w (one quotient bit per
// stage), difference to the target, squares and saturating sum. Depends on hte_pkg.
module hte_xfer import hte_pkg::*; #(
    parameter int NW = FWD_W,
    parameter int DW = FWD_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic                      i_ok,
    input  logic signed [NW-1:0]      i_nx,
    input  logic signed [NW-1:0]      i_ny,
    input  logic signed [DW-1:0]      i_den,
    input  logic signed [COORD_W-1:0] i_tx,
    input  logic signed [COORD_W-1:0] i_ty,
    output t_xfer_res                 o_res
);
    localparam int MW = (NW + COORD_FRAC > DW + QUOT_W) ? NW + COORD_FRAC : DW + QUOT_W;
    localparam int ST = QUOT_W;
    localparam int XW = QUOT_W + 3;

    typedef struct packed {
        logic                      ok;
        logic                      negx;
        logic                      negy;
        logic                      clx;
        logic                      cly;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
    } t_side;

    logic              r_vld [0:ST];
    t_side             r_sd  [0:ST];
    logic [MW-1:0]     r_rx  [0:ST];
    logic [MW-1:0]     r_ry  [0:ST];
    logic [DW-1:0]     r_dn  [0:ST];
    logic [QUOT_W-1:0] r_qx  [0:ST];
    logic [QUOT_W-1:0] r_qy  [0:ST];

    logic [NW-1:0] n_ax, n_ay;
    logic [MW-1:0] n_mx, n_my, n_lim;
    t_side         n_sd;

    always_comb begin
        n_ax    = i_nx[NW-1] ? -i_nx : i_nx;
        n_ay    = i_ny[NW-1] ? -i_ny : i_ny;
        n_mx    = MW'(n_ax) << COORD_FRAC;
        n_my    = MW'(n_ay) << COORD_FRAC;
        n_lim   = MW'(DW'(i_den)) << QUOT_W;
        n_sd.ok   = i_ok && !i_den[DW-1] && (i_den != '0);
        n_sd.negx = i_nx[NW-1];
        n_sd.negy = i_ny[NW-1];
        n_sd.clx  = (n_mx >= n_lim);
        n_sd.cly  = (n_my >= n_lim);
        n_sd.tx   = i_tx;
        n_sd.ty   = i_ty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= n_sd;
            r_rx[0] <= n_mx;
            r_ry[0] <= n_my;
            r_dn[0] <= i_den;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
        end
    end

    for (genvar k = 1; k <= ST; k++) begin : g_div
        localparam int B = ST - k;
        localparam logic [QUOT_W-1:0] QBIT = QUOT_W'(1) << B;
        logic [MW-1:0] sub;
        logic          gx, gy;

        assign sub = MW'(r_dn[k-1]) << B;
        assign gx  = (r_rx[k-1] >= sub);
        assign gy  = (r_ry[k-1] >= sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[k] <= r_sd[k-1];
                r_dn[k] <= r_dn[k-1];
                r_rx[k] <= gx ? r_rx[k-1] - sub : r_rx[k-1];
                r_ry[k] <= gy ? r_ry[k-1] - sub : r_ry[k-1];
                r_qx[k] <= gx ? (r_qx[k-1] | QBIT) : r_qx[k-1];
                r_qy[k] <= gy ? (r_qy[k-1] | QBIT) : r_qy[k-1];
            end
        end
    end

    // quotient sign, clamp and difference to the target
    logic [QUOT_W:0]          n_qmx, n_qmy;
    logic signed [QUOT_W+1:0] n_qsx, n_qsy;
    logic signed [XW-1:0]     n_dx, n_dy;
    logic signed [XW-1:0]     r_dx, r_dy;
    logic                     r_va, r_oka;

    always_comb begin
        n_qmx = r_sd[ST].clx ? {1'b1, QUOT_W'(0)} : {1'b0, r_qx[ST]};
        n_qmy = r_sd[ST].cly ? {1'b1, QUOT_W'(0)} : {1'b0, r_qy[ST]};
        n_qsx = $signed({1'b0, n_qmx});
        n_qsy = $signed({1'b0, n_qmy});
        if (r_sd[ST].negx) begin
            n_qsx = -n_qsx;
        end
        if (r_sd[ST].negy) begin
            n_qsy = -n_qsy;
        end
        n_dx = XW'($signed(r_sd[ST].tx)) - XW'(n_qsx);
        n_dy = XW'($signed(r_sd[ST].ty)) - XW'(n_qsy);
    end

    // magnitude; anything at or above 2^32 saturates the error
    logic [XW-1:0]      n_adx, n_ady;
    logic [COORD_W-1:0] r_mx, r_my;
    logic               r_bigx, r_bigy, r_vb, r_okb;

    assign n_adx = r_dx[XW-1] ? -r_dx : r_dx;
    assign n_ady = r_dy[XW-1] ? -r_dy : r_dy;

    logic [ERR_W-1:0] r_sqx, r_sqy;
    logic             r_bigc, r_vc, r_okc;
    logic [ERR_W:0]   n_sum;
    t_xfer_res        r_res;

    assign n_sum = (ERR_W+1)'(r_sqx) + (ERR_W+1)'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_vc  <= 1'b0;
            r_res <= '0;
        end else if (i_en) begin
            r_va      <= r_vld[ST];
            r_vb      <= r_va;
            r_vc      <= r_vb;
            r_res.valid <= r_vc;
            r_res.ok    <= r_okc;
            r_res.err   <= (r_bigc || n_sum[ERR_W]) ? '1 : n_sum[ERR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_oka  <= r_sd[ST].ok;
            r_mx   <= n_adx[COORD_W-1:0];
            r_my   <= n_ady[COORD_W-1:0];
            r_bigx <= |n_adx[XW-1:COORD_W];
            r_bigy <= |n_ady[XW-1:COORD_W];
            r_okb  <= r_oka;
            r_sqx  <= r_mx * r_mx;
            r_sqy  <= r_my * r_my;
            r_bigc <= r_bigx || r_bigy;
            r_okc  <= r_okb;
        end
    end

    assign o_res = r_res;
endmodule

// File: design/homography_transfer_error.sv
// Homography transfer error scorer, top level.
// Depends on hte_pkg, hte_in_if, hte_out_if, hte_mul, hte_coef, hte_xfer.
//
// Channels: i_pt takes one correspondence (first_x/y, second_x/y, Q16.16) per transfer;
// o_res returns one squared error (Q32.32, saturating) with is_infinite and error_side.
// Coefficients are written on i_cfg_we/i_cfg_idx/i_cfg_data while no point is in flight.
// Throughput: one point per cycle while the pipeline is not frozen. The result path runs
// through the 8-stage input delay that covers the adjugate/determinant settle time, the
// 48 one-bit divider stages and the multiplier and error stages around them.
// All point stages share one enable (the coefficient pipeline runs free): when o_res holds
// a result that is not taken, the pipeline freezes and i_pt.ready drops; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the identity matrix.
// With SYMMETRIC cleared only the forward transfer is built and error_side is always 1.
module homography_transfer_error import hte_pkg::*; #(
    parameter bit SYMMETRIC = SYMMETRIC_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    hte_in_if.sink               i_pt,
    hte_out_if.source            o_res
);
    localparam int DLY = CFG_SETTLE;
    localparam int FPW = COEF_W + COORD_W;

    t_coef            r_coef [COEF_CNT];
    t_pts             r_dl [0:DLY+2];
    logic             r_dv [0:DLY+2];
    logic             en;
    logic             r_ov;
    logic [ERR_W-1:0] r_err;
    logic             r_inf, r_side;
    t_xfer_res        w_fwd, w_bwd;

    assign en         = !r_ov || o_res.ready;
    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COEF_CNT; k++) begin
                r_coef[k] <= '0;
            end
            r_coef[CFG_COEF_00] <= COEF_ONE;
            r_coef[CFG_COEF_11] <= COEF_ONE;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DLY + 2; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= i_pt.valid;
            for (int k = 1; k <= DLY + 2; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0].fx <= i_pt.first_x;
            r_dl[0].fy <= i_pt.first_y;
            r_dl[0].sx <= i_pt.second_x;
            r_dl[0].sy <= i_pt.second_y;
            for (int k = 1; k <= DLY + 2; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // forward: H * (fx, fy, 1)
    logic signed [FPW-1:0]   w_fm [6];
    logic signed [FWD_W-1:0] r_u, r_v, r_w;

    for (genvar g = 0; g < 6; g++) begin : g_fmul
        hte_mul #(.AW(COEF_W), .BW(COORD_W)) u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_coef[g + g/2]),
            .i_b   ((g % 2 == 0) ? r_dl[DLY-1].fx : r_dl[DLY-1].fy),
            .o_p   (w_fm[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u <= FWD_W'(w_fm[0]) + FWD_W'(w_fm[1])
                 + (FWD_W'(r_coef[CFG_COEF_02]) <<< COORD_FRAC);
            r_v <= FWD_W'(w_fm[2]) + FWD_W'(w_fm[3])
                 + (FWD_W'(r_coef[CFG_COEF_12]) <<< COORD_FRAC);
            r_w <= FWD_W'(w_fm[4]) + FWD_W'(w_fm[5]) + FWD_ONE;
        end
    end

    hte_xfer #(.NW(FWD_W), .DW(FWD_W)) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_dv[DLY+2]),
        .i_ok    (1'b1),
        .i_nx    (r_u),
        .i_ny    (r_v),
        .i_den   (r_w),
        .i_tx    (r_dl[DLY+2].sx),
        .i_ty    (r_dl[DLY+2].sy),
        .o_res   (w_fwd)
    );

    if (SYMMETRIC) begin : g_bwd
        localparam int BPW = ADJ_W + COORD_W;
        t_adj                    w_adj [ADJ_CNT];
        logic                    w_det_nz;
        logic signed [BPW-1:0]   w_bm [6];
        logic signed [BWD_W-1:0] r_p, r_r, r_q;

        hte_coef u_coef (
            .i_clk    (i_clk),
            .i_coef   (r_coef),
            .o_adj    (w_adj),
            .o_det_nz (w_det_nz)
        );

        for (genvar g = 0; g < 6; g++) begin : g_bmul
            hte_mul #(.AW(ADJ_W), .BW(COORD_W)) u_mul (
                .i_clk (i_clk),
                .i_en  (en),
                .i_a   (w_adj[g + g/2]),
                .i_b   ((g % 2 == 0) ? r_dl[DLY-1].sx : r_dl[DLY-1].sy),
                .o_p   (w_bm[g])
            );
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p <= BWD_W'(w_bm[0]) + BWD_W'(w_bm[1]) + (BWD_W'(w_adj[2]) <<< COORD_FRAC);
                r_r <= BWD_W'(w_bm[2]) + BWD_W'(w_bm[3]) + (BWD_W'(w_adj[5]) <<< COORD_FRAC);
                r_q <= BWD_W'(w_bm[4]) + BWD_W'(w_bm[5]) + (BWD_W'(w_adj[8]) <<< COORD_FRAC);
            end
        end

        hte_xfer #(.NW(BWD_W), .DW(BWD_W)) u_bwd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_dv[DLY+2]),
            .i_ok    (w_det_nz),
            .i_nx    (r_p),
            .i_ny    (r_r),
            .i_den   (r_q),
            .i_tx    (r_dl[DLY+2].fx),
            .i_ty    (r_dl[DLY+2].fy),
            .o_res   (w_bwd)
        );
    end else begin : g_nobwd
        assign w_bwd = '0;
    end

    logic n_use;
    assign n_use = w_bwd.ok && w_fwd.ok && (w_bwd.err > w_fwd.err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= w_fwd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_err  <= !w_fwd.ok ? '1 : (n_use ? w_bwd.err : w_fwd.err);
            r_inf  <= !w_fwd.ok;
            r_side <= !n_use;
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.squared_error = r_err;
    assign o_res.is_infinite   = r_inf;
    assign o_res.error_side    = r_side;
endmodule

// File: tb/homography_transfer_error_tb.sv
// Testbench for homography_transfer_error: streams point correspondences under several
// homographies and checks every scored error against an in-bench predictor.
// Depends on hte_pkg, hte_in_if, hte_out_if and the RTL of homography_transfer_error.
`timescale 1ns / 100ps

module homography_transfer_error_tb;
    import hte_pkg::*;

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic [ERR_W-1:0] squared_error;
        logic             is_infinite;
        logic             error_side;
    } t_score;

    class score_board;
        t_score pending[$];
        int     errors;

        function void note_point(t_score s);
            pending = {pending, s};
        endfunction

        function void check_result(t_score got);
            t_score want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h/%b/%b", $time,
                         got.squared_error, got.is_infinite, got.error_side);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.squared_error !== want.squared_error) begin
                $display("%0t squared_error exp %h got %h", $time,
                         want.squared_error, got.squared_error);
                errors++;
            end
            if (got.is_infinite !== want.is_infinite) begin
                $display("%0t is_infinite exp %b got %b", $time,
                         want.is_infinite, got.is_infinite);
                errors++;
            end
            if (got.error_side !== want.error_side) begin
                $display("%0t error_side exp %b got %b", $time,
                         want.error_side, got.error_side);
                errors++;
            end
        endfunction
    endclass

    localparam bit SYMM = 1'b1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    hte_in_if  pt_if();
    hte_out_if res_if();

    homography_transfer_error #(.SYMMETRIC(SYMM)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_res      (res_if)
    );

    score_board sb;
    t_coef      coef_m[COEF_CNT];
    bit         calm;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("homography_transfer_error: mismatch");
        $finish;
    end

    function automatic t_wide quot(t_wide num, t_wide den);
        t_wide mag;
        t_wide q;
        bit    neg;
        neg = num < 0;
        mag = (neg ? -num : num) <<< 16;
        if (mag >= (den <<< 48)) q = t_wide'(1) <<< 48;
        else q = mag / den;
        return neg ? -q : q;
    endfunction

    function automatic bit map_point(t_wide nx, t_wide ny, t_wide den, t_wide tx, t_wide ty,
                                     output logic [ERR_W-1:0] err);
        t_wide dx;
        t_wide dy;
        t_wide s;
        err = '1;
        if (den <= 0) return 1'b0;
        dx = tx - quot(nx, den);
        dy = ty - quot(ny, den);
        s  = dx * dx + dy * dy;
        if ((s >>> 64) != 0) err = '1;
        else err = s[ERR_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_score score_point(t_pts p);
        t_wide h[COEF_CNT];
        t_wide fx, fy, sx, sy, u, v, w, one;
        t_wide a00, a01, a02, a10, a11, a12, a20, a21, a22, det, bp, br, bq;
        logic [ERR_W-1:0] err, err1;
        bit     fwd_ok;
        t_score r;
        for (int i = 0; i < COEF_CNT; i++) h[i] = coef_m[i];
        fx = p.fx;
        fy = p.fy;
        sx = p.sx;
        sy = p.sy;
        one = t_wide'(1) <<< 32;
        u = h[0] * fx + h[1] * fy + (h[2] <<< 16);
        v = h[3] * fx + h[4] * fy + (h[5] <<< 16);
        w = h[6] * fx + h[7] * fy + (t_wide'(1) <<< 48);
        fwd_ok = map_point(u, v, w, sx, sy, err);
        if (!fwd_ok) err = '1;
        r.error_side = 1'b1;
        if (SYMM) begin
            a00 = h[4] * one - h[5] * h[7];
            a01 = h[2] * h[7] - h[1] * one;
            a02 = h[1] * h[5] - h[2] * h[4];
            a10 = h[5] * h[6] - h[3] * one;
            a11 = h[0] * one - h[2] * h[6];
            a12 = h[2] * h[3] - h[0] * h[5];
            a20 = h[3] * h[7] - h[4] * h[6];
            a21 = h[1] * h[6] - h[0] * h[7];
            a22 = h[0] * h[4] - h[1] * h[3];
            det = h[0] * a00 + h[1] * a10 + h[2] * a20;
            if (det != 0) begin
                bp = a00 * sx + a01 * sy + (a02 <<< 16);
                br = a10 * sx + a11 * sy + (a12 <<< 16);
                bq = a20 * sx + a21 * sy + (a22 <<< 16);
                if (det < 0) begin
                    bp = -bp;
                    br = -br;
                    bq = -bq;
                end
                if (fwd_ok && map_point(bp, br, bq, fx, fy, err1) && err1 > err) begin
                    err = err1;
                    r.error_side = 1'b0;
                end
            end
        end
        r.squared_error = err;
        r.is_infinite   = !fwd_ok;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pts p;
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            p.fx = pt_if.first_x;
            p.fy = pt_if.first_y;
            p.sx = pt_if.second_x;
            p.sy = pt_if.second_y;
            sb.note_point(score_point(p));
        end
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result({res_if.squared_error, res_if.is_infinite, res_if.error_side});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else res_if.ready <= calm || ($urandom_range(99) >= 29);
    end

    task automatic send_point(t_pts p);
        while (!calm && $urandom_range(99) < 29) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid    <= 1'b1;
        pt_if.first_x  <= p.fx;
        pt_if.first_y  <= p.fy;
        pt_if.second_x <= p.sx;
        pt_if.second_y <= p.sy;
        do @(posedge i_clk); while (!(pt_if.valid && pt_if.ready));
    endtask

    task automatic drain();
        pt_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic load_coefs(t_coef c[COEF_CNT]);
        for (int i = 0; i < COEF_CNT; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= c[i];
            @(posedge i_clk);
            coef_m[i] = c[i];
        end
        i_cfg_we <= 1'b0;
        repeat (2 * CFG_SETTLE) @(posedge i_clk);
    endtask

    function automatic t_coef rnd_full();
        return t_coef'({$urandom, $urandom});
    endfunction

    function automatic t_coef near(t_coef base, int spread);
        return base + t_coef'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    function automatic t_pts rnd_pts(bit wild);
        t_pts p;
        logic signed [COORD_W-1:0] nx, ny;
        if (wild || $urandom_range(9) == 0) begin
            p = {$urandom, $urandom, $urandom, $urandom};
        end else begin
            p.fx = $signed($urandom_range(131072000)) - 65536000;
            p.fy = $signed($urandom_range(131072000)) - 65536000;
            nx   = $signed($urandom_range(2000000)) - 1000000;
            ny   = $signed($urandom_range(2000000)) - 1000000;
            p.sx = p.fx + nx;
            p.sy = p.fy + ny;
        end
        return p;
    endfunction

    task automatic directed_points();
        t_pts p;
        logic signed [COORD_W-1:0] mx, mn;
        mx = {1'b0, {(COORD_W-1){1'b1}}};
        mn = {1'b1, {(COORD_W-1){1'b0}}};
        send_point('0);
        p = {32'sd65536, 32'sd131072, 32'sd65536, 32'sd131072};
        send_point(p);
        p = {mx, mx, mx, mx};
        send_point(p);
        p = {mn, mn, mn, mn};
        send_point(p);
        p = {mx, mn, mn, mx};
        send_point(p);
        p = {mn, mx, mx, mn};
        send_point(p);
        p = {32'sd0, 32'sd0, 32'sd196608, -32'sd262144};
        send_point(p);
        p = {-32'sd1, 32'sd1, 32'sd1, -32'sd1};
        send_point(p);
    endtask

    initial begin
        t_coef c[COEF_CNT];
        int    items;
        sb          = new();
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        pt_if.valid    = 1'b0;
        pt_if.first_x  = '0;
        pt_if.first_y  = '0;
        pt_if.second_x = '0;
        pt_if.second_y = '0;
        for (int i = 0; i < COEF_CNT; i++) coef_m[i] = '0;
        coef_m[CFG_COEF_00] = COEF_ONE;
        coef_m[CFG_COEF_11] = COEF_ONE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_points();
        drain();

        // zero matrix: det is zero, forward w stays one
        foreach (c[i]) c[i] = '0;
        load_coefs(c);
        directed_points();
        drain();

        // strong negative perspective term: forward w goes nonpositive for larger fx
        foreach (c[i]) c[i] = '0;
        c[CFG_COEF_00] = COEF_ONE;
        c[CFG_COEF_11] = COEF_ONE;
        c[CFG_COEF_20] = -COEF_ONE;
        load_coefs(c);
        directed_points();
        drain();

        foreach (c[i]) c[i] = {1'b0, {(COEF_W-1){1'b1}}};
        load_coefs(c);
        directed_points();
        drain();

        foreach (c[i]) c[i] = {1'b1, {(COEF_W-1){1'b0}}};
        load_coefs(c);
        directed_points();
        drain();

        items = 0;
        for (int phase = 0; phase < 11; phase++) begin
            if (phase % 4 == 3) begin
                foreach (c[i]) c[i] = rnd_full();
            end else begin
                c[CFG_COEF_00] = near(COEF_ONE, 1 << 28);
                c[CFG_COEF_01] = near('0, 1 << 26);
                c[CFG_COEF_02] = near('0, 1 << 30) <<< 8;
                c[CFG_COEF_10] = near('0, 1 << 26);
                c[CFG_COEF_11] = near(COEF_ONE, 1 << 28);
                c[CFG_COEF_12] = near('0, 1 << 30) <<< 8;
                c[CFG_COEF_20] = near('0, 1 << 16);
                c[CFG_COEF_21] = near('0, 1 << 16);
            end
            if (phase == 5) begin
                c[CFG_COEF_20] = '0;
                c[CFG_COEF_21] = '0;
            end
            load_coefs(c);
            calm = (phase == 6);
            for (int k = 0; k < 50; k++) begin
                send_point(rnd_pts(phase % 4 == 3));
                items++;
                if (k == 25 && phase == 2) begin
                    pt_if.valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end
        calm = 1'b0;

        if (sb.errors == 0) begin
            $display("homography_transfer_error: match");
        end else begin
            $display("homography_transfer_error: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
design/hte_pkg.sv
design/hte_in_if.sv
design/hte_out_if.sv
design/hte_mul.sv
design/hte_coef.sv
design/hte_xfer.sv
design/homography_transfer_error.sv
tb/homography_transfer_error_tb.sv
